FILE: sv/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
package lpd_pkg;

  localparam int unsigned LenW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [1:0] HDR_LAST_IDX = 2'd3;
  localparam logic [LenW-1:0] MAX_LEN_RESET = 32'd65536;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
    logic             err;
  } res_t;

  typedef struct packed {
    logic       in_payload;
    logic [1:0] hdr_cnt;
  } stat_t;

endpackage

FILE: sv/length_prefix_deframer_unit.sv
// Top level of the length-prefix deframer: input register, parser, result register.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] payload_byte, tlast, tuser err
//  cfg       in   cfg_we_i                      cfg_wdata_i[31:0] max_payload_length
//
//  One byte per cycle while the sink is ready; input register, then result register.
//  Header bytes and accepted headers give no output transfer.
//  Reset clears control state and loads the maximum length with 65536.
//  A stalled sink stops the parser; the input register still takes one byte.
module length_prefix_deframer_unit import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,   // [7:0] payload_byte
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,   // [0] length_error
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i
);

  logic [LenW-1:0]  max_len_q;
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_free;
  logic             adv;
  res_t             res;
  stat_t            stat;

  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  lpd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res),
    .stat_o    (stat)
  );

  lpd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .res_i    (res),
    .tready_i (m_axis_tready),
    .free_o   (out_free),
    .tvalid_o (m_axis_tvalid),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .tuser_o  (m_axis_tuser)
  );

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("error transfer carries data or last");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  a_payload_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.in_payload |-> stat.hdr_cnt == 2'd0)
    else $error("header count moved during payload");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_free |=> in_vld_q && $stable(in_byte_q))
    else $error("input register lost a byte during a stall");

endmodule

FILE: sv/lpd_parser.sv
// Header gathering, length check and payload countdown for one byte per cycle while adv_i is high.
module lpd_parser import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [LenW-1:0]  max_len_i,
  output res_t             res_o,
  output stat_t            stat_o
);

  logic             in_payload_q, in_payload_d;
  logic [1:0]       hdr_cnt_q, hdr_cnt_d;
  logic [23:0]      acc_q, acc_d;
  logic [LenW-1:0]  remain_q, remain_d;
  logic [LenW-1:0]  full_len;
  logic             last;

  assign full_len = {byte_i, acc_q};
  assign last     = (remain_q <= 32'd1);

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    acc_d        = acc_q;
    remain_d     = remain_q;
    res_o        = '0;
    if (in_payload_q) begin
      res_o.valid = 1'b1;
      res_o.data  = byte_i;
      res_o.last  = last;
      if (last) begin
        in_payload_d = 1'b0;
        remain_d     = '0;
      end else begin
        remain_d = remain_q - 32'd1;
      end
    end else if (hdr_cnt_q != HDR_LAST_IDX) begin
      case (hdr_cnt_q)
        2'd0:    acc_d = {16'd0, byte_i};
        2'd1:    acc_d = {8'd0, byte_i, acc_q[7:0]};
        default: acc_d = {byte_i, acc_q[15:0]};
      endcase
      hdr_cnt_d = hdr_cnt_q + 2'd1;
    end else begin
      hdr_cnt_d = '0;
      acc_d     = '0;
      if (full_len == '0 || full_len > max_len_i) begin
        res_o.valid = 1'b1;
        res_o.err   = 1'b1;
      end else begin
        remain_d     = full_len;
        in_payload_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      acc_q        <= '0;
      remain_q     <= '0;
    end else if (adv_i) begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      acc_q        <= acc_d;
      remain_q     <= remain_d;
    end
  end

  assign stat_o.in_payload = in_payload_q;
  assign stat_o.hdr_cnt    = hdr_cnt_q;

endmodule

FILE: sv/lpd_out_reg.sv
// Result register holding one output transfer until the sink takes it.
module lpd_out_reg import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  res_t             res_i,
  input  logic             tready_i,
  output logic             free_o,
  output logic             tvalid_o,
  output logic [ByteW-1:0] tdata_o,
  output logic             tlast_o,
  output logic             tuser_o
);

  logic             vld_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;
  logic             err_q;

  assign free_o = !vld_q || tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_i.valid) begin
      data_q <= res_i.data;
      last_q <= res_i.last;
      err_q  <= res_i.err;
    end
  end

  assign tvalid_o = vld_q;
  assign tdata_o  = data_q;
  assign tlast_o  = last_q;
  assign tuser_o  = err_q;

endmodule
